[hdl/ucd_pkg.sv]
// shared types and constants of the utf-8 code point decoder
package ucd_pkg;

  localparam int unsigned CP_W      = 21;
  localparam int unsigned PARTIAL_W = 18;
  localparam int unsigned CNT_W     = 3;

  localparam logic [CP_W-1:0] QMARK = CP_W'(8'h3F);

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;

  // outcome of one byte: cnt results, all '?' but the last, which is cp/repl
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [CP_W-1:0]  cp;
    logic             repl;
  } step_t;

endpackage

[hdl/ucd_if.sv]
// valid/ready channels for byte requests and code point results
interface ucd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       string_end;

  modport source (output valid, data_byte, string_end, input ready);
  modport sink   (input valid, data_byte, string_end, output ready);
endinterface

interface ucd_cp_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        replaced;
  logic        last_of_run;

  modport source (output valid, code_point, replaced, last_of_run, input ready);
  modport sink   (input valid, code_point, replaced, last_of_run, output ready);
endinterface

[hdl/ucd_step.sv]
// sequence state and per-byte decode logic
module ucd_step import ucd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] data_byte,
  input  logic       string_end,
  output step_t      res
);

  logic [1:0]           need, need_next;
  logic [1:0]           taken, taken_next;
  logic [PARTIAL_W-1:0] partial, partial_next;

  logic                 is_cont;
  logic [CP_W-1:0]      joined;
  logic [1:0]           need_dec;
  logic [1:0]           taken_inc;
  logic [CNT_W-1:0]     flushed;

  always_comb begin
    is_cont   = (data_byte & CONT_MASK) == CONT_CODE;
    joined    = {partial[CP_W-7:0], data_byte[5:0]};
    need_dec  = need - 2'd1;
    taken_inc = taken + 2'd1;
    flushed   = (need != 2'd0) ? CNT_W'(taken) + CNT_W'(1) : '0;

    need_next    = need;
    taken_next   = taken;
    partial_next = partial;
    res.cnt      = '0;
    res.cp       = QMARK;
    res.repl     = 1'b1;

    if (need != 2'd0 && is_cont) begin
      if (need_dec == 2'd0) begin
        res.cnt      = CNT_W'(1);
        res.cp       = joined;
        res.repl     = 1'b0;
        need_next    = '0;
        taken_next   = '0;
        partial_next = '0;
      end else if (string_end) begin
        // cut short: lead plus every continuation taken so far
        res.cnt      = CNT_W'(taken_inc) + CNT_W'(1);
        need_next    = '0;
        taken_next   = '0;
        partial_next = '0;
      end else begin
        need_next    = need_dec;
        taken_next   = taken_inc;
        partial_next = joined[PARTIAL_W-1:0];
      end
    end else begin
      // broken sequence flushes first, then the byte is decoded afresh
      need_next    = '0;
      taken_next   = '0;
      partial_next = '0;
      res.cnt      = flushed;
      if (data_byte[7] == 1'b0) begin
        res.cnt  = flushed + CNT_W'(1);
        res.cp   = CP_W'(data_byte);
        res.repl = 1'b0;
      end else if ((data_byte & LEAD2_MASK) == LEAD2_CODE ||
                   (data_byte & LEAD3_MASK) == LEAD3_CODE ||
                   (data_byte & LEAD4_MASK) == LEAD4_CODE) begin
        if (string_end) begin
          res.cnt = flushed + CNT_W'(1);
        end else if ((data_byte & LEAD2_MASK) == LEAD2_CODE) begin
          need_next    = 2'd1;
          partial_next = PARTIAL_W'(data_byte[4:0]);
        end else if ((data_byte & LEAD3_MASK) == LEAD3_CODE) begin
          need_next    = 2'd2;
          partial_next = PARTIAL_W'(data_byte[3:0]);
        end else begin
          need_next    = 2'd3;
          partial_next = PARTIAL_W'(data_byte[2:0]);
        end
      end else begin
        res.cnt = flushed + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      need    <= '0;
      taken   <= '0;
      partial <= '0;
    end else if (advance) begin
      need    <= need_next;
      taken   <= taken_next;
      partial <= partial_next;
    end
  end

endmodule

[hdl/ucd_emit.sv]
// result register that plays out the results of one byte, one per cycle while cp_out is ready
module ucd_emit import ucd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  step_t           step,
  output logic            free,
  ucd_cp_if.source        cp_out
);

  logic [CNT_W-1:0] cnt;
  logic [CP_W-1:0]  last_cp;
  logic             last_repl;

  assign free = (cnt == '0) || (cnt == CNT_W'(1) && cp_out.ready);

  assign cp_out.valid       = cnt != '0;
  assign cp_out.last_of_run = cnt == CNT_W'(1);
  assign cp_out.code_point  = (cnt == CNT_W'(1)) ? last_cp : QMARK;
  assign cp_out.replaced    = (cnt == CNT_W'(1)) ? last_repl : 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= step.cnt;
    end else if (cp_out.valid && cp_out.ready) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last_cp   <= step.cp;
      last_repl <= step.repl;
    end
  end

endmodule

[hdl/utf8_codepoint_decoder.sv]
// Decodes a UTF-8 byte stream into code points. A byte request is taken into an input
// register; the decode logic and sequence state sit between it and a result register.
// Well-formed input runs at one byte per cycle while cp_out is ready, with one result
// per ASCII byte or completed sequence and none for lead or middle bytes. A malformed
// byte produces up to four results (one '?' for a broken lead and each continuation
// taken, then the byte), which the result register plays out one at a time, holding
// the next byte in the input register. Results of one byte end with last_of_run set.
module utf8_codepoint_decoder import ucd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ucd_byte_if.sink  byte_in,
  ucd_cp_if.source  cp_out
);

  logic       held;
  logic [7:0] held_byte;
  logic       held_end;
  logic       free;
  logic       advance;
  step_t      step;

  assign advance       = held && free;
  assign byte_in.ready = !held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (byte_in.ready) begin
      held <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      held_byte <= byte_in.data_byte;
      held_end  <= byte_in.string_end;
    end
  end

  ucd_step u_step (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .data_byte  (held_byte),
    .string_end (held_end),
    .res        (step)
  );

  ucd_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .load   (advance),
    .step   (step),
    .free   (free),
    .cp_out (cp_out)
  );

endmodule

[bench/utf8_codepoint_decoder_tb.sv]
// testbench for the utf-8 code point decoder: byte requests in, checked code points out
`timescale 1ns / 1ps

module utf8_codepoint_decoder_tb import ucd_pkg::*;;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            replaced;
    logic            last_of_run;
  } cp_result_t;

  logic clk = 1'b0;
  logic rst;

  ucd_byte_if byte_bus ();
  ucd_cp_if   cp_bus ();

  utf8_codepoint_decoder DUT (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_bus),
    .cp_out  (cp_bus)
  );

  always #5 clk = ~clk;

  // predicted decoder state
  logic [1:0]           seq_need;
  logic [1:0]           seq_taken;
  logic [PARTIAL_W-1:0] seq_partial;

  cp_result_t pending_cps [$];
  cp_result_t want_cp;
  int         mismatches = 0;
  int         src_idle_pct = 0;
  int         sink_stall_pct = 0;
  int         bytes_sent = 0;

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, field, got, want);
    mismatches++;
  endtask

  // expected code points for one accepted byte request
  function automatic void predict_cps(input logic [7:0] b, input logic str_end);
    cp_result_t      run [4];
    int              n;
    logic [CP_W-1:0] acc;
    logic            fresh;
    n = 0;
    fresh = 1'b1;
    if (seq_need != 2'd0) begin
      if ((b & CONT_MASK) == CONT_CODE) begin
        fresh = 1'b0;
        acc = CP_W'({seq_partial, b[5:0]});
        seq_need = seq_need - 2'd1;
        if (seq_need == 2'd0) begin
          run[n] = '{acc, 1'b0, 1'b0};
          n++;
          seq_taken = 2'd0;
          seq_partial = '0;
        end else begin
          seq_taken = seq_taken + 2'd1;
          seq_partial = acc[PARTIAL_W-1:0];
        end
      end else begin
        // broken sequence: one '?' for the lead and each continuation taken
        repeat (int'(seq_taken) + 1) begin
          run[n] = '{QMARK, 1'b1, 1'b0};
          n++;
        end
        seq_need = 2'd0;
        seq_taken = 2'd0;
        seq_partial = '0;
      end
    end
    if (fresh) begin
      if (b < 8'h80) begin
        run[n] = '{CP_W'(b), 1'b0, 1'b0};
        n++;
      end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
        seq_need = 2'd1;
        seq_taken = 2'd0;
        seq_partial = PARTIAL_W'(b & ~LEAD2_MASK);
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
        seq_need = 2'd2;
        seq_taken = 2'd0;
        seq_partial = PARTIAL_W'(b & ~LEAD3_MASK);
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
        seq_need = 2'd3;
        seq_taken = 2'd0;
        seq_partial = PARTIAL_W'(b & ~LEAD4_MASK);
      end else begin
        run[n] = '{QMARK, 1'b1, 1'b0};
        n++;
      end
    end
    // string end flushes an open sequence
    if (str_end && seq_need != 2'd0) begin
      repeat (int'(seq_taken) + 1) begin
        run[n] = '{QMARK, 1'b1, 1'b0};
        n++;
      end
      seq_need = 2'd0;
      seq_taken = 2'd0;
      seq_partial = '0;
    end
    if (n > 0) run[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) pending_cps.push_back(run[i]);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic str_end);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_bus.valid <= 1'b0;
      @(posedge clk);
    end
    byte_bus.valid      <= 1'b1;
    byte_bus.data_byte  <= b;
    byte_bus.string_end <= str_end;
    @(posedge clk);
    while (!byte_bus.ready) @(posedge clk);
    predict_cps(b, str_end);
    bytes_sent++;
  endtask

  function automatic logic [7:0] ascii_byte();
    return 8'($urandom_range(1, 127));
  endfunction

  function automatic logic [7:0] cont_byte();
    return CONT_CODE | 8'($urandom_range(0, 63));
  endfunction

  function automatic logic [7:0] lead_byte(input int len);
    case (len)
      2: return LEAD2_CODE | 8'($urandom_range(0, 31));
      3: return LEAD3_CODE | 8'($urandom_range(0, 15));
      default: return LEAD4_CODE | 8'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [7:0] non_cont_byte();
    case ($urandom_range(0, 2))
      0: return ascii_byte();
      1: return lead_byte($urandom_range(2, 4));
      default: return 8'($urandom_range(248, 255));
    endcase
  endfunction

  function automatic logic rand_end();
    return ($urandom_range(7) == 0);
  endfunction

  // lead (ascii when len is 1) and conts continuations, string end on the last
  task automatic send_seq(input int len, input int conts, input logic end_last);
    if (len == 1) begin
      send_byte(ascii_byte(), end_last);
    end else begin
      send_byte(lead_byte(len), end_last && conts == 0);
    end
    for (int i = 0; i < conts; i++) send_byte(cont_byte(), end_last && i == conts - 1);
  endtask

  task automatic test_ascii();
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_multibyte();
    send_byte(8'hC2, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // full 21-bit code point
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_stray();
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  task automatic test_broken();
    // two continuations taken, then a stray high byte: four results
    send_byte(8'hF0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF8, 1'b0);
    // lead broken by a new lead
    send_byte(8'hC5, 1'b0);
    send_byte(8'hC5, 1'b0);
    send_byte(8'h80, 1'b0);
  endtask

  task automatic test_cut_short();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte(8'hF1, 1'b1);
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct, input int n_bytes);
    int start;
    int len;
    start = bytes_sent;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    while (bytes_sent - start < n_bytes) begin
      len = $urandom_range(1, 4);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_seq(len, len - 1, rand_end());
        4: send_seq(1, 0, rand_end());
        5: begin
          len = $urandom_range(2, 4);
          send_seq(len, $urandom_range(0, len - 2), 1'b0);
          send_byte(non_cont_byte(), rand_end());
        end
        6: begin
          len = $urandom_range(2, 4);
          send_seq(len, $urandom_range(0, len - 2), 1'b1);
        end
        7: send_byte($urandom_range(0, 1) ? cont_byte() : 8'($urandom_range(248, 255)),
                     rand_end());
        default: send_byte(8'($urandom_range(1, 255)), rand_end());
      endcase
    end
  endtask

  task automatic test_random();
    run_phase(0, 0, 34);
    run_phase(59, 0, 34);
    run_phase(0, 59, 34);
    run_phase(7, 7, 34);
  endtask

  // receiver side
  initial begin
    cp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && cp_bus.valid && cp_bus.ready) begin
      if (pending_cps.size() == 0) begin
        report_mismatch("unexpected code_point", cp_bus.code_point, 0);
      end else begin
        want_cp = pending_cps.pop_front();
        if (cp_bus.code_point !== want_cp.code_point)
          report_mismatch("code_point", cp_bus.code_point, want_cp.code_point);
        if (cp_bus.replaced !== want_cp.replaced)
          report_mismatch("replaced", cp_bus.replaced, want_cp.replaced);
        if (cp_bus.last_of_run !== want_cp.last_of_run)
          report_mismatch("last_of_run", cp_bus.last_of_run, want_cp.last_of_run);
      end
    end
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    rst                 <= 1'b1;
    byte_bus.valid      <= 1'b0;
    byte_bus.data_byte  <= 8'h00;
    byte_bus.string_end <= 1'b0;
    seq_need    = 2'd0;
    seq_taken   = 2'd0;
    seq_partial = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_ascii();
    test_multibyte();
    test_stray();
    test_broken();
    test_cut_short();
    test_random();

    src_idle_pct = 0;
    sink_stall_pct = 0;
    byte_bus.valid <= 1'b0;
    while (pending_cps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && pending_cps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/ucd_pkg.sv
hdl/ucd_if.sv
hdl/ucd_step.sv
hdl/ucd_emit.sv
hdl/utf8_codepoint_decoder.sv
bench/utf8_codepoint_decoder_tb.sv
